/* src/fdscp_pkg.sv */
// Shared types, codes and reset constants for the close-page FIFO scheduler.
`default_nettype none
package fdscp_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned NUM_BANKS_DEF   = 8;

	localparam int unsigned TAG_W   = 16;
	localparam int unsigned BANK_W  = 3;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned ERR_W   = 2;
	localparam int unsigned MASK_W  = 8;
	localparam int unsigned CFG_IW  = 2;
	localparam int unsigned CFG_DW  = 5;
	localparam int unsigned LIMIT_W = 5;
	localparam int unsigned BCNT_W  = 4;

	localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EVENT = 2'd2;

	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL     = 2'd1;
	localparam logic [ERR_W-1:0] ERR_BANK_OOR = 2'd2;

	localparam logic [CFG_IW-1:0] REG_CLOSE_PAGE  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_QUEUE_LIMIT = 2'd1;
	localparam logic [CFG_IW-1:0] REG_BANK_COUNT  = 2'd2;

	localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = 5'd16;
	localparam logic [BCNT_W-1:0]  BANK_COUNT_RST  = 4'd8;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [BANK_W-1:0] bank;
	} q_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

endpackage
`default_nettype wire

/* src/fdscp_queue.sv */
// In-order transaction queue storage with pointers and a registered head read.
`default_nettype none
module fdscp_queue #(
	parameter int unsigned QUEUE_DEPTH = fdscp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire fdscp_pkg::q_ctl_t   ctl,
	input  wire fdscp_pkg::q_entry_t wr_entry,
	output fdscp_pkg::q_entry_t      head_entry
);
	import fdscp_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	q_entry_t mem [QUEUE_DEPTH];
	q_entry_t head_q;
	logic [PW-1:0] head_ptr_q;
	logic [PW-1:0] tail_ptr_q;
	logic [PW-1:0] head_d;
	logic [PW-1:0] head_inc;
	logic [PW-1:0] tail_inc;

	assign head_inc = (head_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr_q + PW'(1);
	assign tail_inc = (tail_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr_q + PW'(1);
	assign head_d   = ctl.pop ? head_inc : head_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			tail_ptr_q <= '0;
		end else begin
			head_ptr_q <= head_d;
			if (ctl.push) begin
				tail_ptr_q <= tail_inc;
			end
		end
	end

	// The head entry is prefetched into a register; a write to that slot is forwarded.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_ptr_q] <= wr_entry;
		end
		if (ctl.push && (tail_ptr_q == head_d)) begin
			head_q <= wr_entry;
		end else begin
			head_q <= mem[head_d];
		end
	end

	assign head_entry = head_q;

endmodule
`default_nettype wire

/* src/fifo_dram_scheduler_close_page_top.sv */
// Top level of the FIFO memory scheduler with close-page precharge selection.
// An accepted item is registered in the input stage, its result in the result register.
// One item per cycle unless stalled; queue and bank state update in the result cycle.
// The head entry of the queue memory is prefetched into a register each cycle.
// Reset clears pointers, counters and handshake state and restores register defaults.
// The queue memory is not cleared; an entry is only popped after it was written.
`default_nettype none
module fifo_dram_scheduler_close_page_top #(
	parameter int unsigned QUEUE_DEPTH = fdscp_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned NUM_BANKS   = fdscp_pkg::NUM_BANKS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [fdscp_pkg::CFG_IW-1:0]       cfg_index,
	input  wire [fdscp_pkg::CFG_DW-1:0]       cfg_data,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire [fdscp_pkg::KIND_W-1:0]       kind,
	input  wire [fdscp_pkg::TAG_W-1:0]        tag,
	input  wire [fdscp_pkg::BANK_W-1:0]       bank,
	input  wire                               has_current,
	input  wire [fdscp_pkg::MASK_W-1:0]       open_row_mask,
	input  wire [fdscp_pkg::MASK_W-1:0]       precharge_ok_mask,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic                              popped_valid,
	output logic [fdscp_pkg::TAG_W-1:0]       popped_tag,
	output logic [fdscp_pkg::BANK_W-1:0]      popped_bank,
	output logic                              precharge_valid,
	output logic [fdscp_pkg::BANK_W-1:0]      precharge_bank,
	output logic                              accept_more,
	output logic [fdscp_pkg::ERR_W-1:0]       error
);
	import fdscp_pkg::*;

	localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned LW  = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;
	localparam int unsigned BKW = BCNT_W + 1;

	// Configuration registers.
	logic               close_page_q;
	logic [LIMIT_W-1:0] queue_limit_q;
	logic [BCNT_W-1:0]  bank_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_page_q  <= 1'b0;
			queue_limit_q <= QUEUE_LIMIT_RST;
			bank_count_q  <= BANK_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CLOSE_PAGE:  close_page_q  <= cfg_data[0];
				REG_QUEUE_LIMIT: queue_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_BANK_COUNT:  bank_count_q  <= cfg_data[BCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage.
	logic               valid_s1;
	logic [KIND_W-1:0]  kind_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [BANK_W-1:0]  bank_s1;
	logic               has_cur_s1;
	logic [MASK_W-1:0]  open_s1;
	logic [MASK_W-1:0]  ok_s1;
	logic               out_valid_q;
	logic               fire;

	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1    <= kind;
			tag_s1     <= tag;
			bank_s1    <= bank;
			has_cur_s1 <= has_current;
			open_s1    <= open_row_mask;
			ok_s1      <= precharge_ok_mask;
		end
	end

	// Queue bookkeeping.
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  count_d;
	logic [LW-1:0]  limit_eff;
	logic [BKW-1:0] banks_eff;
	logic           is_push;
	logic           is_pop;
	logic           full;
	logic           bank_bad;
	logic           push_ok;
	logic           pop_ok;
	logic [ERR_W-1:0] err_d;
	q_ctl_t         q_ctl;
	q_entry_t       head_entry;
	q_entry_t       wr_entry;

	assign limit_eff = (LW'(queue_limit_q) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH)
		: LW'(queue_limit_q);
	assign banks_eff = (BKW'(bank_count_q) > BKW'(NUM_BANKS)) ? BKW'(NUM_BANKS)
		: BKW'(bank_count_q);

	assign is_push  = (kind_s1 == KIND_PUSH);
	assign is_pop   = (kind_s1 == KIND_POP);
	assign full     = LW'(count_q) >= limit_eff;
	assign bank_bad = BKW'(bank_s1) >= banks_eff;
	assign push_ok  = fire && is_push && !full && !bank_bad;
	assign pop_ok   = fire && is_pop && (count_q != '0);

	always_comb begin
		err_d = ERR_NONE;
		if (is_push) begin
			if (full) begin
				err_d = ERR_FULL;
			end else if (bank_bad) begin
				err_d = ERR_BANK_OOR;
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + CW'(1);
		end else if (pop_ok) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign q_ctl.push     = push_ok;
	assign q_ctl.pop      = pop_ok;
	assign wr_entry.tag   = tag_s1;
	assign wr_entry.bank  = bank_s1;

	fdscp_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (q_ctl),
		.wr_entry   (wr_entry),
		.head_entry (head_entry)
	);

	// Pending accesses per bank.
	logic [CW-1:0]     pending_q [NUM_BANKS];
	logic [MASK_W-1:0] cand;

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_pend
		logic inc;
		logic dec;
		assign inc = push_ok && (BKW'(bank_s1) == BKW'(b));
		assign dec = pop_ok && (BKW'(head_entry.bank) == BKW'(b)) && (pending_q[b] != '0);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pending_q[b] <= '0;
			end else if (inc) begin
				pending_q[b] <= pending_q[b] + CW'(1);
			end else if (dec) begin
				pending_q[b] <= pending_q[b] - CW'(1);
			end
		end
	end

	for (genvar i = 0; i < MASK_W; i++) begin : g_cand
		if (i < NUM_BANKS) begin : g_on
			assign cand[i] = close_page_q && (kind_s1 == KIND_EVENT)
				&& (BKW'(i) < banks_eff)
				&& !(has_cur_s1 && (bank_s1 == BANK_W'(i)))
				&& (pending_q[i] == '0) && open_s1[i] && ok_s1[i];
		end else begin : g_off
			assign cand[i] = 1'b0;
		end
	end

	logic              pre_v_d;
	logic [BANK_W-1:0] pre_b_d;

	always_comb begin
		pre_v_d = 1'b0;
		pre_b_d = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				pre_v_d = 1'b1;
				pre_b_d = BANK_W'(i);
			end
		end
	end

	// Result register.
	logic              pop_v_q;
	logic [TAG_W-1:0]  pop_tag_q;
	logic [BANK_W-1:0] pop_bank_q;
	logic              pre_v_q;
	logic [BANK_W-1:0] pre_b_q;
	logic              more_q;
	logic [ERR_W-1:0]  err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pop_v_q    <= pop_ok;
			pop_tag_q  <= pop_ok ? head_entry.tag : '0;
			pop_bank_q <= pop_ok ? head_entry.bank : '0;
			pre_v_q    <= pre_v_d;
			pre_b_q    <= pre_b_d;
			more_q     <= (LW'(count_d) + LW'(1)) < limit_eff;
			err_q      <= err_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign popped_valid    = pop_v_q;
	assign popped_tag      = pop_tag_q;
	assign popped_bank     = pop_bank_q;
	assign precharge_valid = pre_v_q;
	assign precharge_bank  = pre_b_q;
	assign accept_more     = more_q;
	assign error           = err_q;

	// A dropped push leaves the queue occupancy unchanged.
	a_drop_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_push && (err_d != ERR_NONE) |=> count_q == $past(count_q))
		else $error("dropped push changed the queue count");

	// The occupancy never exceeds the storage depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(count_q) <= LW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// A result never reports a pop together with a precharge or an error.
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pop_v_q |-> !pre_v_q && (err_q == ERR_NONE))
		else $error("pop result mixed with precharge or error");

	// A precharged bank had no pending access when it was chosen.
	a_pre_idle_bank: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pre_v_d |-> (pending_q[pre_b_d] == '0) && !push_ok && !pop_ok)
		else $error("precharge chosen for a busy bank");

endmodule
`default_nettype wire

/* tb/sv/fifo_dram_scheduler_close_page_top_tb.sv */
// Self-checking testbench for the close-page FIFO memory scheduler: directed table, then random phases.
module fifo_dram_scheduler_close_page_top_tb;
	import fdscp_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int BANKS = NUM_BANKS_DEF;
	localparam int HANG_LIMIT = 2000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TAG_W-1:0]  tag;
		logic [BANK_W-1:0] bank;
		logic              has_cur;
		logic [MASK_W-1:0] open_rows;
		logic [MASK_W-1:0] pre_ok;
	} sched_item_t;

	typedef struct packed {
		logic              pv;
		logic [TAG_W-1:0]  ptag;
		logic [BANK_W-1:0] pbank;
		logic              prv;
		logic [BANK_W-1:0] prbank;
		logic              more;
		logic [ERR_W-1:0]  err;
	} sched_result_t;

	typedef struct {
		logic               setup;
		logic               close_page;
		logic [LIMIT_W-1:0] limit;
		logic [BCNT_W-1:0]  banks;
		sched_item_t        item;
		logic               known;
		sched_result_t      res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [KIND_W-1:0] kind = KIND_POP;
	logic [TAG_W-1:0] tag = '0;
	logic [BANK_W-1:0] bank = '0;
	logic has_current = 1'b0;
	logic [MASK_W-1:0] open_row_mask = '0;
	logic [MASK_W-1:0] precharge_ok_mask = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic popped_valid;
	logic [TAG_W-1:0] popped_tag;
	logic [BANK_W-1:0] popped_bank;
	logic precharge_valid;
	logic [BANK_W-1:0] precharge_bank;
	logic accept_more;
	logic [ERR_W-1:0] error;

	logic idle_on = 1'b1;
	int fails = 0;
	int hang = 0;
	sched_result_t expected_results[$];

	logic [TAG_W-1:0] q_tag [DEPTH];
	logic [BANK_W-1:0] q_bank [DEPTH];
	int q_head = 0;
	int q_tail = 0;
	int q_count = 0;
	int bank_busy [BANKS] = '{default: 0};
	logic cfg_close = 1'b0;
	logic [LIMIT_W-1:0] cfg_limit = QUEUE_LIMIT_RST;
	logic [BCNT_W-1:0] cfg_banks = BANK_COUNT_RST;

	dir_row_t dir_rows [28] = '{
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_POP, 16'h0000, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b1, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_PUSH, 16'hffff, 3'd7, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b1, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_PUSH, 16'h0000, 3'd0, 1'b1, 8'hff, 8'hff},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b1, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_EVENT, 16'h0000, 3'd0, 1'b0, 8'hff, 8'hff},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b1, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_UNUSED, 16'hffff, 3'd7, 1'b1, 8'hff, 8'hff},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b1, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_POP, 16'h0000, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b1, 16'hffff, 3'd7, 1'b0, 3'd0, 1'b1, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_POP, 16'h0000, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b1, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b1, ERR_NONE}},
		'{1'b1, 1'b1, 5'd2, 4'd1, '0, 1'b0, '0},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_PUSH, 16'h1234, 3'd1, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b1, ERR_BANK_OOR}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_PUSH, 16'h5555, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b0, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_EVENT, 16'h0000, 3'd0, 1'b0, 8'hff, 8'hff},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b0, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_PUSH, 16'haaaa, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b0, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_PUSH, 16'h0000, 3'd7, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b0, ERR_FULL}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_POP, 16'h0000, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b1, 16'h5555, 3'd0, 1'b0, 3'd0, 1'b0, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_POP, 16'h0000, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b1, 16'haaaa, 3'd0, 1'b0, 3'd0, 1'b1, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_EVENT, 16'h0000, 3'd0, 1'b1, 8'hff, 8'hff},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b1, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_EVENT, 16'h0000, 3'd0, 1'b0, 8'h01, 8'h01},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b1, 3'd0, 1'b1, ERR_NONE}},
		'{1'b1, 1'b1, 5'd31, 4'd15, '0, 1'b0, '0},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_PUSH, 16'h0000, 3'd7, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b1, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_EVENT, 16'h0000, 3'd3, 1'b1, 8'hff, 8'hff},
			1'b0, '0},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_EVENT, 16'h0000, 3'd0, 1'b0, 8'hff, 8'h7e},
			1'b0, '0},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_EVENT, 16'h0000, 3'd1, 1'b1, 8'h42, 8'h42},
			1'b0, '0},
		'{1'b1, 1'b1, 5'd1, 4'd0, '0, 1'b0, '0},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_PUSH, 16'hffff, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b0, ERR_FULL}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_EVENT, 16'h0000, 3'd0, 1'b0, 8'hff, 8'hff},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b0, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_POP, 16'h0000, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b1, 16'h0000, 3'd7, 1'b0, 3'd0, 1'b0, ERR_NONE}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_PUSH, 16'h0000, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b0, ERR_BANK_OOR}},
		'{1'b0, 1'b0, 5'd0, 4'd0, '{KIND_POP, 16'h0000, 3'd0, 1'b0, 8'h00, 8'h00},
			1'b1, '{1'b0, 16'h0000, 3'd0, 1'b0, 3'd0, 1'b0, ERR_NONE}}
	};

	fifo_dram_scheduler_close_page_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.tag(tag),
		.bank(bank),
		.has_current(has_current),
		.open_row_mask(open_row_mask),
		.precharge_ok_mask(precharge_ok_mask),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.popped_valid(popped_valid),
		.popped_tag(popped_tag),
		.popped_bank(popped_bank),
		.precharge_valid(precharge_valid),
		.precharge_bank(precharge_bank),
		.accept_more(accept_more),
		.error(error)
	);

	always #1 clk = ~clk;

	function automatic void enqueue_expect(input sched_result_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic sched_result_t dequeue_expect();
		sched_result_t r;
		r = expected_results[0];
		expected_results.delete(0);
		return r;
	endfunction

	function automatic sched_result_t schedule_step(sched_item_t it);
		sched_result_t r;
		int lim;
		int nb;
		r = '0;
		lim = (cfg_limit > DEPTH) ? DEPTH : int'(cfg_limit);
		nb = (cfg_banks > BANKS) ? BANKS : int'(cfg_banks);
		case (it.kind)
		KIND_PUSH: begin
			if (q_count >= lim) begin
				r.err = ERR_FULL;
			end else if (it.bank >= nb) begin
				r.err = ERR_BANK_OOR;
			end else begin
				q_tag[q_tail] = it.tag;
				q_bank[q_tail] = it.bank;
				q_tail = (q_tail + 1) % DEPTH;
				q_count++;
				bank_busy[it.bank]++;
			end
		end
		KIND_POP: begin
			if (q_count > 0) begin
				r.pv = 1'b1;
				r.ptag = q_tag[q_head];
				r.pbank = q_bank[q_head];
				q_head = (q_head + 1) % DEPTH;
				q_count--;
				if (bank_busy[r.pbank] > 0)
					bank_busy[r.pbank]--;
			end
		end
		KIND_EVENT: begin
			if (cfg_close) begin
				for (int i = 0; i < nb && i < MASK_W; i++) begin
					if (!r.prv && !(it.has_cur && i == it.bank) && bank_busy[i] == 0
							&& it.open_rows[i] && it.pre_ok[i]) begin
						r.prv = 1'b1;
						r.prbank = BANK_W'(i);
					end
				end
			end
		end
		default: ;
		endcase
		r.more = (q_count + 1 < lim);
		return r;
	endfunction

	task automatic check_result(input sched_result_t want, input sched_result_t got);
		if (got.pv !== want.pv) begin
			$error("popped_valid expected %0d got %0d", want.pv, got.pv);
			fails++;
		end
		if (got.ptag !== want.ptag) begin
			$error("popped_tag expected %h got %h", want.ptag, got.ptag);
			fails++;
		end
		if (got.pbank !== want.pbank) begin
			$error("popped_bank expected %0d got %0d", want.pbank, got.pbank);
			fails++;
		end
		if (got.prv !== want.prv) begin
			$error("precharge_valid expected %0d got %0d", want.prv, got.prv);
			fails++;
		end
		if (got.prbank !== want.prbank) begin
			$error("precharge_bank expected %0d got %0d", want.prbank, got.prbank);
			fails++;
		end
		if (got.more !== want.more) begin
			$error("accept_more expected %0d got %0d", want.more, got.more);
			fails++;
		end
		if (got.err !== want.err) begin
			$error("error expected %0d got %0d", want.err, got.err);
			fails++;
		end
	endtask

	task automatic send_item(input sched_item_t it, input logic known, input sched_result_t typed);
		sched_result_t predicted;
		while (idle_on && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		kind <= it.kind;
		tag <= it.tag;
		bank <= it.bank;
		has_current <= it.has_cur;
		open_row_mask <= it.open_rows;
		precharge_ok_mask <= it.pre_ok;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predicted = schedule_step(it);
		enqueue_expect(known ? typed : predicted);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_CLOSE_PAGE: cfg_close = val[0];
		REG_QUEUE_LIMIT: cfg_limit = LIMIT_W'(val);
		REG_BANK_COUNT: cfg_banks = BCNT_W'(val);
		default: ;
		endcase
	endtask

	task automatic apply_settings(input logic close, input logic [LIMIT_W-1:0] lim,
			input logic [BCNT_W-1:0] nb);
		cfg_write(REG_CLOSE_PAGE, CFG_DW'(close));
		cfg_write(REG_QUEUE_LIMIT, CFG_DW'(lim));
		cfg_write(REG_BANK_COUNT, CFG_DW'(nb));
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		out_ready <= !idle_on || ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result beat with no item outstanding");
				fails++;
			end else begin
				check_result(dequeue_expect(), {popped_valid, popped_tag,
					popped_bank, precharge_valid, precharge_bank, accept_more, error});
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			hang = 0;
		else
			hang++;
		if (hang >= HANG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		sched_item_t it;
		int push_pct;
		int r;
		int nb;
		logic cp;
		logic [LIMIT_W-1:0] lim;
		logic [BCNT_W-1:0] bc;
		push_pct = 50;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].setup) begin
				settle();
				apply_settings(dir_rows[k].close_page, dir_rows[k].limit, dir_rows[k].banks);
			end else begin
				send_item(dir_rows[k].item, dir_rows[k].known, dir_rows[k].res);
			end
		end

		for (int ph = 0; ph < 10; ph++) begin
			settle();
			cp = (ph % 3 != 2);
			lim = (ph == 1) ? 5'd2 : (ph == 7) ? 5'd31 : LIMIT_W'($urandom_range(16, 2));
			bc = (ph == 2) ? 4'd1 : (ph == 7) ? 4'd15 : (ph == 4) ? 4'd8
				: BCNT_W'($urandom_range(8, 1));
			apply_settings(cp, lim, bc);
			idle_on = (ph != 5);
			nb = (bc > BANKS) ? BANKS : int'(bc);
			for (int n = 0; n < 108; n++) begin
				if (n % 36 == 0)
					push_pct = 25 * $urandom_range(3, 1);
				if (ph == 3 && n == 54)
					settle();
				r = $urandom_range(99);
				if (r < 2)
					it.kind = KIND_UNUSED;
				else if (r < push_pct)
					it.kind = KIND_PUSH;
				else if (r < push_pct + (100 - push_pct) / 2)
					it.kind = KIND_POP;
				else
					it.kind = KIND_EVENT;
				it.tag = TAG_W'($urandom());
				if (nb == 0 || $urandom_range(9) == 0)
					it.bank = BANK_W'($urandom_range(7));
				else
					it.bank = BANK_W'($urandom_range(nb - 1));
				it.has_cur = 1'($urandom_range(1));
				it.open_rows = MASK_W'($urandom_range(255));
				it.pre_ok = MASK_W'($urandom_range(255));
				if ($urandom_range(1) == 1)
					it.pre_ok = it.pre_ok | it.open_rows;
				send_item(it, 1'b0, '0);
			end
		end

		settle();
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
